// ===== hdl/obtl_pkg.sv =====
package obtl_pkg;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_REMOVE  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND,
    ST_WRITE,
    ST_LVL_SCAN,
    ST_LVL_EMIT,
    ST_DONE
  } state_t;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int KEY_W   = 64;
  localparam int TOTAL_W = 40;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ===== hdl/obtl_ram.sv =====
module obtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/order_book_top_levels_core.sv =====
// order book top levels: per-order table with top-of-book aggregation
// timing: levels are produced by repeated sequential scans of the entry memory
// throughput: one input transfer at a time, busy drops in the cycle that drives the last level
// reset: synchronous active low, then a clearing pass over the entry memory during
//   which busy is high; results cannot be stalled
module order_book_top_levels_core #(
  parameter int MAX_ORDERS   = 1024,
  parameter int SHOWN_LEVELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_order_key,
  input  logic        in_buy_side,
  input  logic [31:0] in_order_price,
  input  logic [31:0] in_order_qty,
  output logic        out_strobe,
  output logic        out_bid_level,
  output logic [1:0]  out_level_rank,
  output logic [31:0] out_level_price,
  output logic [39:0] out_level_total,
  output logic        out_table_overflow,
  output logic        out_last_level
);

  localparam int AW = $clog2(MAX_ORDERS);
  // rank counter is at least as wide as the rank port
  localparam int RW = (SHOWN_LEVELS < 3) ? 2 : $clog2(SHOWN_LEVELS + 1);
  // entry word: valid, buy, key, price, qty
  localparam int EW = 2 + obtl_pkg::KEY_W + obtl_pkg::PRICE_W + obtl_pkg::QTY_W;

  obtl_pkg::state_t state_r, state_nxt;

  // latched command
  logic [1:0]  kind_r;
  logic [63:0] key_r;
  logic        buy_r;
  logic [31:0] price_r, qty_r;

  // scan address (issued) and pipeline tag for data coming back
  logic [AW:0]   addr_r, addr_nxt;
  logic          rvld_r, rvld_nxt;
  logic [AW-1:0] raddr_q_r;

  // search results
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic          ovf_r, ovf_nxt;

  // level scan state
  logic          side_r, side_nxt;       // 0 ask, 1 bid
  logic [RW-1:0] rank_r, rank_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   best_r, best_nxt;
  logic [39:0]   sum_r, sum_nxt;
  logic          any_r, any_nxt;         // a level already emitted for this item

  // pending emit register (one behind, so last_level can be set late)
  logic        pend_r, pend_nxt;
  logic        pbid_r, pbid_nxt;
  logic [1:0]  prank_r, prank_nxt;
  logic [31:0] pprice_r, pprice_nxt;
  logic [39:0] ptot_r, ptot_nxt;

  logic        ostb_r, ostb_nxt, olast_r, olast_nxt;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  obtl_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic        e_valid, e_buy;
  logic [63:0] e_key;
  logic [31:0] e_price, e_qty;
  assign {e_valid, e_buy, e_key, e_price, e_qty} = rdata;

  logic [40:0] add_w;
  assign add_w = {1'b0, sum_r} + {9'd0, e_qty};

  logic        scan_end;
  assign scan_end = (addr_r == (AW+1)'(MAX_ORDERS));

  // entry that counts for this level pass
  logic        elig, better, same;
  always_comb begin
    elig = e_valid && (e_buy == side_r);
    if (rank_r != '0) begin
      elig = elig && (side_r ? (e_price < prev_r) : (e_price > prev_r));
    end
    better = !found_r || (side_r ? (e_price > best_r) : (e_price < best_r));
    same   = found_r && (e_price == best_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obtl_pkg::ST_CLEAR;
      addr_r  <= '0;
      rvld_r  <= 1'b0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      rvld_r  <= rvld_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r  <= in_kind;
      key_r   <= in_order_key;
      buy_r   <= in_buy_side;
      price_r <= in_order_price;
      qty_r   <= in_order_qty;
    end
    raddr_q_r  <= raddr;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    side_r     <= side_nxt;
    rank_r     <= rank_nxt;
    prev_r     <= prev_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    sum_r      <= sum_nxt;
    any_r      <= any_nxt;
    pbid_r     <= pbid_nxt;
    prank_r    <= prank_nxt;
    pprice_r   <= pprice_nxt;
    ptot_r     <= ptot_nxt;
    olast_r    <= olast_nxt;
  end

  // output port registers
  always_ff @(posedge clk) begin
    if (pend_r && (ostb_nxt)) begin
      out_bid_level      <= pbid_r;
      out_level_rank     <= prank_r;
      out_level_price    <= pprice_r;
      out_level_total    <= ptot_r;
      out_table_overflow <= ovf_r;
    end
  end
  assign out_strobe     = ostb_r;
  assign out_last_level = olast_r;
  assign busy = (state_r != obtl_pkg::ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    rvld_nxt     = 1'b0;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    ovf_nxt      = ovf_r;
    side_nxt     = side_r;
    rank_nxt     = rank_r;
    prev_nxt     = prev_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    sum_nxt      = sum_r;
    any_nxt      = any_r;
    pend_nxt     = pend_r;
    pbid_nxt     = pbid_r;
    prank_nxt    = prank_r;
    pprice_nxt   = pprice_r;
    ptot_nxt     = ptot_r;
    ostb_nxt     = 1'b0;
    olast_nxt    = 1'b0;
    we           = 1'b0;
    waddr        = addr_r[AW-1:0];
    wdata        = '0;
    raddr        = addr_r[AW-1:0];

    case (state_r)
      obtl_pkg::ST_CLEAR: begin
        we       = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (AW+1)'(MAX_ORDERS - 1)) begin
          state_nxt = obtl_pkg::ST_IDLE;
        end
      end

      obtl_pkg::ST_IDLE: begin
        if (start) begin
          addr_nxt  = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = obtl_pkg::ST_FIND;
        end
      end

      obtl_pkg::ST_FIND: begin
        // issue reads, check each returned entry in the cycle after its read
        if (!scan_end) begin
          rvld_nxt = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
        if (rvld_r) begin
          if (e_valid && e_key == key_r && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = raddr_q_r;
          end
          if (!e_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = raddr_q_r;
          end
        end
        if (scan_end && !rvld_r) begin
          state_nxt = obtl_pkg::ST_WRITE;
        end
      end

      obtl_pkg::ST_WRITE: begin
        if (kind_r == obtl_pkg::KIND_ADD || kind_r == obtl_pkg::KIND_REPLACE) begin
          if (hit_r || free_r) begin
            we    = 1'b1;
            waddr = hit_r ? hit_idx_r : free_idx_r;
            wdata = {1'b1, buy_r, key_r, price_r, qty_r};
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (kind_r == obtl_pkg::KIND_REMOVE && hit_r) begin
          we    = 1'b1;
          waddr = hit_idx_r;
          wdata = '0;
        end
        side_nxt  = 1'b0;
        rank_nxt  = '0;
        any_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        addr_nxt  = '0;
        found_nxt = 1'b0;
        state_nxt = obtl_pkg::ST_LVL_SCAN;
      end

      obtl_pkg::ST_LVL_SCAN: begin
        // one pass finds best next price and sums its quantity
        if (!scan_end) begin
          rvld_nxt = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
        if (rvld_r && elig) begin
          if (same) begin
            sum_nxt = add_w[40] ? obtl_pkg::TOTAL_MAX : add_w[39:0];
          end else if (better) begin
            found_nxt = 1'b1;
            best_nxt  = e_price;
            sum_nxt   = {8'd0, e_qty};
          end
        end
        if (scan_end && !rvld_r) begin
          state_nxt = obtl_pkg::ST_LVL_EMIT;
        end
      end

      obtl_pkg::ST_LVL_EMIT: begin
        addr_nxt  = '0;
        found_nxt = 1'b0;
        if (found_r) begin
          // flush previously held level, hold this one
          if (pend_r) begin
            ostb_nxt = 1'b1;
          end
          pend_nxt   = 1'b1;
          pbid_nxt   = side_r;
          prank_nxt  = rank_r[1:0];
          pprice_nxt = best_r;
          ptot_nxt   = sum_r;
          prev_nxt   = best_r;
          any_nxt    = 1'b1;
        end
        if (found_r && rank_r != RW'(SHOWN_LEVELS - 1)) begin
          rank_nxt  = rank_r + 1'b1;
          state_nxt = obtl_pkg::ST_LVL_SCAN;
        end else if (!side_r) begin
          side_nxt  = 1'b1;
          rank_nxt  = '0;
          state_nxt = obtl_pkg::ST_LVL_SCAN;
        end else begin
          state_nxt = obtl_pkg::ST_DONE;
        end
      end

      obtl_pkg::ST_DONE: begin
        if (pend_r) begin
          ostb_nxt  = 1'b1;
          olast_nxt = 1'b1;
        end
        pend_nxt  = 1'b0;
        state_nxt = obtl_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = obtl_pkg::ST_IDLE;
      end
    endcase
  end

  // output register loads when the held level is flushed
  // last level only ever marks a strobe
  assert property (@(posedge clk) disable iff (!rst_n) out_last_level |-> out_strobe)
    else $error("last level without strobe");
  // no results while idle waiting for a command
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == obtl_pkg::ST_IDLE && $past(state_r) == obtl_pkg::ST_IDLE) |-> !out_strobe)
    else $error("strobe while idle");
  // overflow flag is sticky
  assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) && $past(ovf_r) |-> ovf_r)
    else $error("overflow flag cleared");
  // a command is only taken when idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == obtl_pkg::ST_FIND))
    else $error("command not taken");

endmodule

// ===== tb/sv/order_book_levels_checker.sv =====
`timescale 1ns / 1ps

module order_book_levels_checker #(
  parameter int MAX_ORDERS   = 16,
  parameter int SHOWN_LEVELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_order_key,
  input  logic        in_buy_side,
  input  logic [31:0] in_order_price,
  input  logic [31:0] in_order_qty,
  input  logic        out_strobe,
  input  logic        out_bid_level,
  input  logic [1:0]  out_level_rank,
  input  logic [31:0] out_level_price,
  input  logic [39:0] out_level_total,
  input  logic        out_table_overflow,
  input  logic        out_last_level,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        bid;
    logic [1:0]  rank;
    logic [31:0] price;
    logic [39:0] total;
    logic        ovf;
    logic        last;
  } book_level_t;

  logic                        book_valid [MAX_ORDERS];
  logic [obtl_pkg::KEY_W-1:0]  book_key   [MAX_ORDERS];
  logic                        book_buy   [MAX_ORDERS];
  logic [31:0]                 book_price [MAX_ORDERS];
  logic [31:0]                 book_qty   [MAX_ORDERS];
  logic                        book_ovf;
  book_level_t                 level_q [$];

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < MAX_ORDERS; i++)
      if (book_valid[i] && book_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < MAX_ORDERS; i++)
      if (!book_valid[i]) return i;
    return -1;
  endfunction

  task automatic apply_order(obtl_pkg::kind_t k, logic [63:0] key, logic buy,
                             logic [31:0] price, logic [31:0] qty);
    int s;
    int n;
    logic [31:0] prev;
    logic [31:0] best;
    logic found;
    logic [40:0] sum;
    book_level_t lv;
    n = 0;
    if (k == obtl_pkg::KIND_ADD || k == obtl_pkg::KIND_REPLACE) begin
      s = slot_of(key);
      if (s < 0) s = free_slot();
      if (s < 0) book_ovf = 1'b1;
      else begin
        book_valid[s] = 1'b1;
        book_key[s]   = key;
        book_buy[s]   = buy;
        book_price[s] = price;
        book_qty[s]   = qty;
      end
    end else if (k == obtl_pkg::KIND_REMOVE) begin
      s = slot_of(key);
      if (s >= 0) book_valid[s] = 1'b0;
    end
    // asks then bids, best first on each side
    for (int side = 0; side < 2; side++) begin
      prev = '0;
      for (int r = 0; r < SHOWN_LEVELS; r++) begin
        found = 1'b0;
        best = '0;
        for (int i = 0; i < MAX_ORDERS; i++) begin
          if (!book_valid[i] || book_buy[i] != side[0]) continue;
          if (r != 0 && (side ? book_price[i] >= prev : book_price[i] <= prev)) continue;
          if (!found || (side ? book_price[i] > best : book_price[i] < best)) begin
            best = book_price[i];
            found = 1'b1;
          end
        end
        if (!found) break;
        prev = best;
        sum = '0;
        for (int i = 0; i < MAX_ORDERS; i++)
          if (book_valid[i] && book_buy[i] == side[0] && book_price[i] == best) begin
            sum = sum + {9'd0, book_qty[i]};
            if (sum > {1'b0, obtl_pkg::TOTAL_MAX}) sum = {1'b0, obtl_pkg::TOTAL_MAX};
          end
        lv.bid = side[0];
        lv.rank = r[1:0];
        lv.price = best;
        lv.total = sum[39:0];
        lv.ovf = book_ovf;
        lv.last = 1'b0;
        level_q.push_back(lv);
        n++;
      end
    end
    if (n > 0) level_q[level_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    book_level_t got;
    book_level_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDERS; i++) book_valid[i] = 1'b0;
      book_ovf = 1'b0;
      level_q.delete();
    end else begin
      // results first: the last level of one item can share an edge with the next input
      if (out_strobe) begin
        got = '{out_bid_level, out_level_rank, out_level_price, out_level_total,
                out_table_overflow, out_last_level};
        if (level_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected level transfer %p", got);
        end else begin
          want = level_q.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) $display("level mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (start && !busy)
        apply_order(obtl_pkg::kind_t'(in_kind), in_order_key, in_buy_side, in_order_price,
                    in_order_qty);
    end
    pending = level_q.size();
  end

endmodule

// ===== tb/sv/order_book_top_levels_core_test.sv =====
`timescale 1ns / 1ps

module order_book_top_levels_core_test;

  // small table keeps each transfer short and makes overflow reachable
  localparam int BOOK_DEPTH = 16;
  localparam int LEVELS     = 3;
  localparam int RANDOM_ORDERS = 262;
  localparam int DRAIN_CYCLES  = 7 * (BOOK_DEPTH + 2) + BOOK_DEPTH + 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_order_key = '0;
  logic        in_buy_side = 1'b0;
  logic [31:0] in_order_price = '0;
  logic [31:0] in_order_qty = '0;
  logic        out_strobe;
  logic        out_bid_level;
  logic [1:0]  out_level_rank;
  logic [31:0] out_level_price;
  logic [39:0] out_level_total;
  logic        out_table_overflow;
  logic        out_last_level;
  int          errors;
  int          pending;

  logic [63:0] key_pool [20];
  logic [31:0] price_pool [6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  order_book_top_levels_core #(.MAX_ORDERS(BOOK_DEPTH), .SHOWN_LEVELS(LEVELS)) dut (.*);

  order_book_levels_checker #(.MAX_ORDERS(BOOK_DEPTH), .SHOWN_LEVELS(LEVELS)) checker_i (.*);

  // one order transfer; start is left high so back-to-back orders need no glitch
  task automatic send_order(obtl_pkg::kind_t k, logic [63:0] key, logic buy,
                            logic [31:0] price, logic [31:0] qty);
    start <= 1'b1;
    in_kind <= k;
    in_order_key <= key;
    in_buy_side <= buy;
    in_order_price <= price;
    in_order_qty <= qty;
    // busy only moves at rising edges, so its value here holds at the next edge
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // random gap after a transfer: mostly none, some short, a few long
  task automatic idle_gap();
    int g;
    int pick;
    pick = $urandom_range(99);
    g = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(5, 1) : $urandom_range(80, 20);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic random_order();
    int pick;
    obtl_pkg::kind_t k;
    logic [31:0] price;
    logic [31:0] qty;
    pick = $urandom_range(99);
    k = (pick < 40) ? obtl_pkg::KIND_ADD : (pick < 60) ? obtl_pkg::KIND_REPLACE :
        (pick < 90) ? obtl_pkg::KIND_REMOVE : obtl_pkg::KIND_NOP;
    // clustered prices give shared levels and deep ranks, the rest spans the range
    price = ($urandom_range(9) < 8) ? price_pool[$urandom_range(5)] : $urandom;
    pick = $urandom_range(19);
    qty = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
    send_order(k, key_pool[$urandom_range(19)], 1'($urandom_range(1)), price, qty);
  endtask

  initial begin
    // pool of 20 keys over a 16-deep table forces overflow
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 20; i++) key_pool[i] = {$urandom, $urandom};
    price_pool = '{32'd0, 32'd1000, 32'd1001, 32'd1002, 32'd1003, 32'hFFFF_FFFF};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty book, extremes, every kind and its corner cases
    send_order(obtl_pkg::KIND_NOP, '0, 1'b0, '0, '0);                // empty book, no levels
    send_order(obtl_pkg::KIND_ADD, key_pool[0], 1'b0, 32'd0, 32'd0); // zero qty still shown
    send_order(obtl_pkg::KIND_ADD, key_pool[1], 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_gap();
    send_order(obtl_pkg::KIND_ADD, key_pool[2], 1'b0, 32'd1000, 32'hFFFF_FFFF);
    send_order(obtl_pkg::KIND_ADD, key_pool[3], 1'b0, 32'd1000, 32'hFFFF_FFFF); // shared
    send_order(obtl_pkg::KIND_ADD, key_pool[4], 1'b0, 32'd1001, 32'd7);
    send_order(obtl_pkg::KIND_ADD, key_pool[5], 1'b0, 32'd1002, 32'd9); // fourth ask hidden
    send_order(obtl_pkg::KIND_ADD, key_pool[6], 1'b1, 32'd999, 32'd3);
    send_order(obtl_pkg::KIND_ADD, key_pool[7], 1'b1, 32'd998, 32'd4);
    send_order(obtl_pkg::KIND_ADD, key_pool[8], 1'b1, 32'd997, 32'd5);  // fourth bid hidden
    send_order(obtl_pkg::KIND_REPLACE, key_pool[6], 1'b0, 32'd1001, 32'd11); // existing key
    send_order(obtl_pkg::KIND_REPLACE, key_pool[9], 1'b1, 32'd996, 32'd2);   // absent key
    send_order(obtl_pkg::KIND_ADD, key_pool[9], 1'b1, 32'd999, 32'd8);       // add overwrites
    send_order(obtl_pkg::KIND_REMOVE, key_pool[19], 1'b0, '0, '0);           // absent remove
    send_order(obtl_pkg::KIND_REMOVE, key_pool[0], 1'b0, '0, '0);
    send_order(obtl_pkg::KIND_NOP, key_pool[1], 1'b1, 32'd5, 32'd5);
    idle_gap();
    for (int i = 0; i < 10; i++) send_order(obtl_pkg::KIND_REMOVE, key_pool[i], 1'b0, '0, '0);
    send_order(obtl_pkg::KIND_REMOVE, key_pool[1], 1'b0, '0, '0);            // back to empty

    for (int n = 0; n < RANDOM_ORDERS; n++) begin
      random_order();
      if (n == RANDOM_ORDERS / 2) begin
        // hold off until the block has delivered everything
        start <= 1'b0;
        forever begin
          @(negedge clk);
          if (pending == 0) break;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
      end else if (n > 40 && n < 80) begin
        // stretch with no idle cycles at all
      end else begin
        idle_gap();
      end
    end
    start <= 1'b0;

    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
